FILE: rtl/core/fmpf_pkg.sv
package fmpf_pkg;

   localparam int COUNT_WIDTH = 64;
   localparam int NUM_RULES = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int RULE_CTL_WIDTH = 10;
   localparam int RULE_DROP_BIT = 8;
   localparam int RULE_ACTIVE_BIT = 9;

   localparam logic [6:0] POS_MAX = 7'd127;
   localparam logic [6:0] POS_TYPE_HI = 7'd12;
   localparam logic [6:0] POS_TYPE_LO = 7'd13;
   localparam logic [6:0] POS_IHL = 7'd14;
   localparam logic [6:0] POS_PROTO = 7'd23;
   localparam logic [6:0] POS_SRC_FIRST = 7'd26;
   localparam logic [6:0] POS_SRC_LAST = 7'd29;
   localparam logic [6:0] POS_DST_FIRST = 7'd30;
   localparam logic [6:0] POS_DST_LAST = 7'd33;

   localparam logic [7:0] MIN_FRAME_BYTES = 8'd34;
   localparam logic [7:0] ETH_HDR_BYTES = 8'd14;
   localparam logic [3:0] MIN_IHL_WORDS = 4'd5;
   localparam logic [15:0] IPV4_ETHERTYPE = 16'h0800;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RULE0_ADDRESSES = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RULE0_CONTROL = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RULE1_ADDRESSES = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RULE1_CONTROL = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RULE2_ADDRESSES = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RULE2_CONTROL = 3'd5;

   localparam logic [1:0] OUTCOME_INVALID = 2'd0;
   localparam logic [1:0] OUTCOME_RULE_ALLOW = 2'd1;
   localparam logic [1:0] OUTCOME_RULE_DROP = 2'd2;
   localparam logic [1:0] OUTCOME_DEFAULT_ALLOW = 2'd3;
   localparam logic [1:0] NO_RULE = 2'd3;

   typedef struct packed {
      logic        valid;
      logic [31:0] source;
      logic [31:0] destination;
      logic [7:0]  protocol;
   } frame_info_type;

endpackage

FILE: rtl/core/fmpf_parser.sv
module fmpf_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              frame_byte,
   input  logic                    end_of_frame,
   output logic                    push,
   output fmpf_pkg::frame_info_type push_data
);

   logic [6:0]  byte_position_ff, byte_position_in;
   logic [15:0] ether_type_ff, ether_type_in;
   logic [3:0]  header_words_ff, header_words_in;
   logic [7:0]  protocol_ff, protocol_in;
   logic [31:0] source_ff, source_in;
   logic [31:0] destination_ff, destination_in;
   logic [7:0]  frame_len;
   logic [7:0]  ihl_bytes;
   logic        frame_ok;

   always_comb begin
      ether_type_in = ether_type_ff;
      header_words_in = header_words_ff;
      protocol_in = protocol_ff;
      source_in = source_ff;
      destination_in = destination_ff;
      case (byte_position_ff) inside
         fmpf_pkg::POS_TYPE_HI: ether_type_in = {frame_byte, ether_type_ff[7:0]};
         fmpf_pkg::POS_TYPE_LO: ether_type_in = {ether_type_ff[15:8], frame_byte};
         fmpf_pkg::POS_IHL: header_words_in = frame_byte[3:0];
         fmpf_pkg::POS_PROTO: protocol_in = frame_byte;
         [fmpf_pkg::POS_SRC_FIRST:fmpf_pkg::POS_SRC_LAST]:
            source_in = {source_ff[23:0], frame_byte};
         [fmpf_pkg::POS_DST_FIRST:fmpf_pkg::POS_DST_LAST]:
            destination_in = {destination_ff[23:0], frame_byte};
         default: ;
      endcase
      byte_position_in = (byte_position_ff < fmpf_pkg::POS_MAX) ?
                         byte_position_ff + 7'd1 : byte_position_ff;
   end

   // length and header checks use the bytes including this one
   always_comb begin
      frame_len = {1'b0, byte_position_ff} + 8'd1;
      ihl_bytes = {2'b00, header_words_in, 2'b00};
      frame_ok = (frame_len >= fmpf_pkg::MIN_FRAME_BYTES) &&
                 (ether_type_in == fmpf_pkg::IPV4_ETHERTYPE) &&
                 (header_words_in >= fmpf_pkg::MIN_IHL_WORDS) &&
                 (fmpf_pkg::ETH_HDR_BYTES + ihl_bytes <= frame_len);
      push = accept && end_of_frame;
      push_data.valid = frame_ok;
      push_data.source = frame_ok ? source_in : 32'd0;
      push_data.destination = frame_ok ? destination_in : 32'd0;
      push_data.protocol = frame_ok ? protocol_in : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && end_of_frame)) begin
         byte_position_ff <= '0;
         ether_type_ff <= '0;
         header_words_ff <= '0;
         protocol_ff <= '0;
         source_ff <= '0;
         destination_ff <= '0;
      end else if (accept) begin
         byte_position_ff <= byte_position_in;
         ether_type_ff <= ether_type_in;
         header_words_ff <= header_words_in;
         protocol_ff <= protocol_in;
         source_ff <= source_in;
         destination_ff <= destination_in;
      end
   end

endmodule

FILE: rtl/core/fmpf_queue.sv
module fmpf_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  fmpf_pkg::frame_info_type push_data,
   input  logic                    pop,
   output fmpf_pkg::frame_info_type head,
   output logic                    full,
   output logic                    empty
);

   localparam int PtrWidth = $clog2(fmpf_pkg::QUEUE_DEPTH);
   localparam int CountWidth = $clog2(fmpf_pkg::QUEUE_DEPTH + 1);
   localparam logic [CountWidth-1:0] DepthCount = CountWidth'(fmpf_pkg::QUEUE_DEPTH);

   fmpf_pkg::frame_info_type entry_ff [fmpf_pkg::QUEUE_DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CountWidth-1:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + CountWidth'(1);
      else if (pop && !push) count_in = count_ff - CountWidth'(1);
      full = (count_ff == DepthCount);
      empty = (count_ff == '0);
      head = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PtrWidth'(1);
         if (pop) rd_ptr_ff <= rd_ptr_ff + PtrWidth'(1);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

FILE: rtl/core/fmpf_matcher.sv
module fmpf_matcher #(
   parameter int COUNT_WIDTH = fmpf_pkg::COUNT_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [fmpf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [fmpf_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   input  fmpf_pkg::frame_info_type              head,
   input  logic                                  empty,
   output logic                                  pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_drop_frame,
   output logic [1:0]                            rsp_outcome,
   output logic [1:0]                            rsp_matched_rule,
   output logic [31:0]                           rsp_source_address,
   output logic [31:0]                           rsp_destination_address,
   output logic [7:0]                            rsp_ip_protocol,
   output logic [COUNT_WIDTH-1:0]                rsp_frames_seen,
   output logic [COUNT_WIDTH-1:0]                rsp_frames_allowed,
   output logic [COUNT_WIDTH-1:0]                rsp_frames_dropped,
   output logic [COUNT_WIDTH-1:0]                rsp_frames_invalid
);

   logic [63:0] rule_addr_ff [fmpf_pkg::NUM_RULES];
   logic [fmpf_pkg::RULE_CTL_WIDTH-1:0] rule_ctl_ff [fmpf_pkg::NUM_RULES];

   logic                   valid_ff;
   logic                   drop_ff, drop_in;
   logic [1:0]             outcome_ff, outcome_in;
   logic [1:0]             rule_ff, rule_in;
   logic [31:0]            source_ff;
   logic [31:0]            destination_ff;
   logic [7:0]             protocol_ff;
   logic [COUNT_WIDTH-1:0] seen_ff, allowed_ff, dropped_ff, invalid_ff;
   logic [fmpf_pkg::NUM_RULES-1:0] hit;
   logic                   found;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < fmpf_pkg::NUM_RULES; r++) begin
            rule_addr_ff[r] <= '0;
            rule_ctl_ff[r] <= '0;
         end
      end else if (csr_write_enable) begin
         case (csr_index)
            fmpf_pkg::REG_RULE0_ADDRESSES: rule_addr_ff[0] <= csr_write_data;
            fmpf_pkg::REG_RULE0_CONTROL:
               rule_ctl_ff[0] <= csr_write_data[fmpf_pkg::RULE_CTL_WIDTH-1:0];
            fmpf_pkg::REG_RULE1_ADDRESSES: rule_addr_ff[1] <= csr_write_data;
            fmpf_pkg::REG_RULE1_CONTROL:
               rule_ctl_ff[1] <= csr_write_data[fmpf_pkg::RULE_CTL_WIDTH-1:0];
            fmpf_pkg::REG_RULE2_ADDRESSES: rule_addr_ff[2] <= csr_write_data;
            fmpf_pkg::REG_RULE2_CONTROL:
               rule_ctl_ff[2] <= csr_write_data[fmpf_pkg::RULE_CTL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // rule compares in parallel, first hit wins
   always_comb begin
      for (int r = 0; r < fmpf_pkg::NUM_RULES; r++) begin
         hit[r] = rule_ctl_ff[r][fmpf_pkg::RULE_ACTIVE_BIT] &&
                  (rule_addr_ff[r][63:32] == 32'd0 ||
                   rule_addr_ff[r][63:32] == head.source) &&
                  (rule_addr_ff[r][31:0] == 32'd0 ||
                   rule_addr_ff[r][31:0] == head.destination) &&
                  (rule_ctl_ff[r][7:0] == 8'd0 ||
                   rule_ctl_ff[r][7:0] == head.protocol);
      end
      found = 1'b0;
      drop_in = 1'b0;
      rule_in = fmpf_pkg::NO_RULE;
      outcome_in = head.valid ? fmpf_pkg::OUTCOME_DEFAULT_ALLOW : fmpf_pkg::OUTCOME_INVALID;
      if (head.valid) begin
         for (int r = 0; r < fmpf_pkg::NUM_RULES; r++) begin
            if (hit[r] && !found) begin
               found = 1'b1;
               rule_in = 2'(r);
               if (rule_ctl_ff[r][fmpf_pkg::RULE_DROP_BIT]) begin
                  drop_in = 1'b1;
                  outcome_in = fmpf_pkg::OUTCOME_RULE_DROP;
               end else begin
                  outcome_in = fmpf_pkg::OUTCOME_RULE_ALLOW;
               end
            end
         end
      end
      pop = !empty && (!valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         seen_ff <= '0;
         allowed_ff <= '0;
         dropped_ff <= '0;
         invalid_ff <= '0;
      end else begin
         if (pop) begin
            valid_ff <= 1'b1;
            seen_ff <= seen_ff + COUNT_WIDTH'(1);
            if (!head.valid) invalid_ff <= invalid_ff + COUNT_WIDTH'(1);
            else if (drop_in) dropped_ff <= dropped_ff + COUNT_WIDTH'(1);
            else allowed_ff <= allowed_ff + COUNT_WIDTH'(1);
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         drop_ff <= drop_in;
         outcome_ff <= outcome_in;
         rule_ff <= rule_in;
         source_ff <= head.source;
         destination_ff <= head.destination;
         protocol_ff <= head.protocol;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_drop_frame = drop_ff;
   assign rsp_outcome = outcome_ff;
   assign rsp_matched_rule = rule_ff;
   assign rsp_source_address = source_ff;
   assign rsp_destination_address = destination_ff;
   assign rsp_ip_protocol = protocol_ff;
   assign rsp_frames_seen = seen_ff;
   assign rsp_frames_allowed = allowed_ff;
   assign rsp_frames_dropped = dropped_ff;
   assign rsp_frames_invalid = invalid_ff;

endmodule

FILE: rtl/core/ipv4_first_match_packet_filter_unit.sv
// result path: on its final byte a frame's record enters the 4-entry frame queue, then the
// matcher's result register; one frame byte per cycle while req_ready is high, and one
// result per cycle while rsp_ready is high; req_ready drops only while 4 records are queued
// synchronous active-high reset clears rules, counters, parser state and the queue
module ipv4_first_match_packet_filter_unit #(
   parameter int COUNT_WIDTH = fmpf_pkg::COUNT_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [7:0]                            req_frame_byte,
   input  logic                                  req_end_of_frame,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_drop_frame,
   output logic [1:0]                            rsp_outcome,
   output logic [1:0]                            rsp_matched_rule,
   output logic [31:0]                           rsp_source_address,
   output logic [31:0]                           rsp_destination_address,
   output logic [7:0]                            rsp_ip_protocol,
   output logic [COUNT_WIDTH-1:0]                rsp_frames_seen,
   output logic [COUNT_WIDTH-1:0]                rsp_frames_allowed,
   output logic [COUNT_WIDTH-1:0]                rsp_frames_dropped,
   output logic [COUNT_WIDTH-1:0]                rsp_frames_invalid,
   input  logic                                  csr_write_enable,
   input  logic [fmpf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [fmpf_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data
);

   fmpf_pkg::frame_info_type push_data, head;
   logic push, pop, full, empty, accept;

   assign req_ready = !full;
   assign accept = req_valid && req_ready;

   fmpf_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .frame_byte   (req_frame_byte),
      .end_of_frame (req_end_of_frame),
      .push         (push),
      .push_data    (push_data)
   );

   fmpf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .full      (full),
      .empty     (empty)
   );

   fmpf_matcher #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_matcher (
      .clock                   (clock),
      .reset                   (reset),
      .csr_write_enable        (csr_write_enable),
      .csr_index               (csr_index),
      .csr_write_data          (csr_write_data),
      .head                    (head),
      .empty                   (empty),
      .pop                     (pop),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_drop_frame          (rsp_drop_frame),
      .rsp_outcome             (rsp_outcome),
      .rsp_matched_rule        (rsp_matched_rule),
      .rsp_source_address      (rsp_source_address),
      .rsp_destination_address (rsp_destination_address),
      .rsp_ip_protocol         (rsp_ip_protocol),
      .rsp_frames_seen         (rsp_frames_seen),
      .rsp_frames_allowed      (rsp_frames_allowed),
      .rsp_frames_dropped      (rsp_frames_dropped),
      .rsp_frames_invalid      (rsp_frames_invalid)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drop_frame == (rsp_outcome == fmpf_pkg::OUTCOME_RULE_DROP)))
      else $error("drop flag disagrees with outcome");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outcome == fmpf_pkg::OUTCOME_INVALID) |->
      (rsp_matched_rule == fmpf_pkg::NO_RULE && rsp_source_address == 32'd0 &&
       rsp_destination_address == 32'd0 && rsp_ip_protocol == 8'd0))
      else $error("invalid frame carries parsed fields");

   assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_frame) |=> !empty)
      else $error("final byte transaction lost in frame queue");

endmodule

FILE: dv/tb.sv
module tb;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam logic [fmpf_pkg::CSR_INDEX_WIDTH-1:0] REG_UNUSED_LO = 3'd6;
   localparam logic [fmpf_pkg::CSR_INDEX_WIDTH-1:0] REG_UNUSED_HI = 3'd7;
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;
   localparam logic [31:0] HOST_A = 32'hC0A8_0001;
   localparam logic [31:0] HOST_B = 32'h0A00_0002;
   localparam logic [31:0] HOST_C = 32'h0808_0808;
   localparam logic [31:0] HOST_D = 32'hAC10_0005;
   localparam logic [63:0] CTL_JUNK = 64'hFFFF_FFFF_FFFF_FC00;

   typedef struct {
      logic                             drop;
      logic [1:0]                       outcome;
      logic [1:0]                       rule;
      logic [31:0]                      src;
      logic [31:0]                      dst;
      logic [7:0]                       proto;
      logic [fmpf_pkg::COUNT_WIDTH-1:0] seen;
      logic [fmpf_pkg::COUNT_WIDTH-1:0] allowed;
      logic [fmpf_pkg::COUNT_WIDTH-1:0] dropped;
      logic [fmpf_pkg::COUNT_WIDTH-1:0] invalid;
   } filter_verdict_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   logic [7:0]                           req_frame_byte;
   logic                                 req_end_of_frame;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   logic                                 rsp_drop_frame;
   logic [1:0]                           rsp_outcome;
   logic [1:0]                           rsp_matched_rule;
   logic [31:0]                          rsp_source_address;
   logic [31:0]                          rsp_destination_address;
   logic [7:0]                           rsp_ip_protocol;
   logic [fmpf_pkg::COUNT_WIDTH-1:0]     rsp_frames_seen;
   logic [fmpf_pkg::COUNT_WIDTH-1:0]     rsp_frames_allowed;
   logic [fmpf_pkg::COUNT_WIDTH-1:0]     rsp_frames_dropped;
   logic [fmpf_pkg::COUNT_WIDTH-1:0]     rsp_frames_invalid;
   logic                                 csr_write_enable;
   logic [fmpf_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [fmpf_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data;

   ipv4_first_match_packet_filter_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_frame_byte(req_frame_byte),
      .req_end_of_frame(req_end_of_frame),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_drop_frame(rsp_drop_frame),
      .rsp_outcome(rsp_outcome),
      .rsp_matched_rule(rsp_matched_rule),
      .rsp_source_address(rsp_source_address),
      .rsp_destination_address(rsp_destination_address),
      .rsp_ip_protocol(rsp_ip_protocol),
      .rsp_frames_seen(rsp_frames_seen),
      .rsp_frames_allowed(rsp_frames_allowed),
      .rsp_frames_dropped(rsp_frames_dropped),
      .rsp_frames_invalid(rsp_frames_invalid),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // filter model state
   logic [63:0]                         rule_addr [fmpf_pkg::NUM_RULES];
   logic [fmpf_pkg::RULE_CTL_WIDTH-1:0] rule_ctl [fmpf_pkg::NUM_RULES];
   logic [6:0]                          parse_pos;
   logic [15:0]                         parse_type;
   logic [3:0]                          parse_ihl;
   logic [7:0]                          parse_proto;
   logic [31:0]                         parse_src;
   logic [31:0]                         parse_dst;
   logic [fmpf_pkg::COUNT_WIDTH-1:0]    total_seen;
   logic [fmpf_pkg::COUNT_WIDTH-1:0]    total_allowed;
   logic [fmpf_pkg::COUNT_WIDTH-1:0]    total_dropped;
   logic [fmpf_pkg::COUNT_WIDTH-1:0]    total_invalid;

   filter_verdict_type expected_verdicts[$];

   int  error_count = 0;
   int  bytes_sent = 0;
   int  frames_sent = 0;
   int  verdicts_checked = 0;
   int  drops_checked = 0;
   int  invalid_checked = 0;
   int  stall_request = 0;
   bit  sender_gaps = 0;
   bit  receiver_gaps = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void classify_byte(input logic [7:0] b, input logic last);
      logic [6:0]         at;
      int                 len;
      logic               ok;
      logic               decided;
      logic               hit;
      logic [31:0]        rs;
      logic [31:0]        rd;
      logic [7:0]         rp;
      filter_verdict_type v;
      at = parse_pos;
      if (at == fmpf_pkg::POS_TYPE_HI) parse_type[15:8] = b;
      else if (at == fmpf_pkg::POS_TYPE_LO) parse_type[7:0] = b;
      else if (at == fmpf_pkg::POS_IHL) parse_ihl = b[3:0];
      else if (at == fmpf_pkg::POS_PROTO) parse_proto = b;
      else if (at >= fmpf_pkg::POS_SRC_FIRST && at <= fmpf_pkg::POS_SRC_LAST)
         parse_src = {parse_src[23:0], b};
      else if (at >= fmpf_pkg::POS_DST_FIRST && at <= fmpf_pkg::POS_DST_LAST)
         parse_dst = {parse_dst[23:0], b};
      if (at != fmpf_pkg::POS_MAX) parse_pos = at + 7'd1;
      if (!last) return;

      len = int'(at) + 1;
      ok = len >= int'(fmpf_pkg::MIN_FRAME_BYTES) && parse_type == fmpf_pkg::IPV4_ETHERTYPE &&
           parse_ihl >= fmpf_pkg::MIN_IHL_WORDS &&
           int'(fmpf_pkg::ETH_HDR_BYTES) + 4 * int'(parse_ihl) <= len;
      v.drop = 1'b0;
      v.outcome = fmpf_pkg::OUTCOME_INVALID;
      v.rule = fmpf_pkg::NO_RULE;
      v.src = '0;
      v.dst = '0;
      v.proto = '0;
      total_seen = total_seen + 1'b1;
      if (!ok) begin
         total_invalid = total_invalid + 1'b1;
      end else begin
         v.outcome = fmpf_pkg::OUTCOME_DEFAULT_ALLOW;
         decided = 1'b0;
         for (int r = 0; r < fmpf_pkg::NUM_RULES; r++) begin
            rs = rule_addr[r][63:32];
            rd = rule_addr[r][31:0];
            rp = rule_ctl[r][7:0];
            hit = rule_ctl[r][fmpf_pkg::RULE_ACTIVE_BIT] && (rs == 0 || rs == parse_src) &&
                  (rd == 0 || rd == parse_dst) && (rp == 0 || rp == parse_proto);
            if (!decided && hit) begin
               decided = 1'b1;
               v.rule = 2'(r);
               if (rule_ctl[r][fmpf_pkg::RULE_DROP_BIT]) begin
                  v.drop = 1'b1;
                  v.outcome = fmpf_pkg::OUTCOME_RULE_DROP;
               end else begin
                  v.outcome = fmpf_pkg::OUTCOME_RULE_ALLOW;
               end
            end
         end
         if (v.drop) total_dropped = total_dropped + 1'b1;
         else total_allowed = total_allowed + 1'b1;
         v.src = parse_src;
         v.dst = parse_dst;
         v.proto = parse_proto;
      end
      v.seen = total_seen;
      v.allowed = total_allowed;
      v.dropped = total_dropped;
      v.invalid = total_invalid;
      expected_verdicts.push_back(v);
      parse_pos = '0;
      parse_type = '0;
      parse_ihl = '0;
      parse_proto = '0;
      parse_src = '0;
      parse_dst = '0;
   endfunction

   function automatic int pick_gap_length();
      if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] pick_address(input bit source_side);
      int r;
      r = $urandom_range(0, 5);
      if (r < fmpf_pkg::NUM_RULES)
         return source_side ? rule_addr[r][63:32] : rule_addr[r][31:0];
      if (r == fmpf_pkg::NUM_RULES) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   function automatic logic [7:0] pick_protocol();
      int r;
      r = $urandom_range(0, 4);
      if (r < fmpf_pkg::NUM_RULES) return rule_ctl[r][7:0];
      if (r == fmpf_pkg::NUM_RULES) return 8'hFF;
      return 8'($urandom);
   endfunction

   function automatic logic [63:0] control_word(input logic active, input logic drop,
                                                input logic [7:0] proto);
      return {54'h0, active, drop, proto};
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      filter_verdict_type v;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            $error("result transaction with no frame outstanding");
            error_count++;
         end else begin
            v = expected_verdicts.pop_front();
            check_field("drop_frame", v.drop, rsp_drop_frame);
            check_field("outcome", v.outcome, rsp_outcome);
            check_field("matched_rule", v.rule, rsp_matched_rule);
            check_field("source_address", v.src, rsp_source_address);
            check_field("destination_address", v.dst, rsp_destination_address);
            check_field("ip_protocol", v.proto, rsp_ip_protocol);
            check_field("frames_seen", v.seen, rsp_frames_seen);
            check_field("frames_allowed", v.allowed, rsp_frames_allowed);
            check_field("frames_dropped", v.dropped, rsp_frames_dropped);
            check_field("frames_invalid", v.invalid, rsp_frames_invalid);
            verdicts_checked++;
            if (v.drop) drops_checked++;
            if (v.outcome == fmpf_pkg::OUTCOME_INVALID) invalid_checked++;
         end
      end
   end

   // result side: random holds, plus long holds on request
   initial begin
      int hold;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         hold = 0;
         if (stall_request > 0) begin
            hold = stall_request;
            stall_request = 0;
         end else if (receiver_gaps && $urandom_range(0, 99) < 25) begin
            hold = pick_gap_length();
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = (sender_gaps && $urandom_range(0, 99) >= 70) ? pick_gap_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_frame_byte <= b;
      req_end_of_frame <= last;
      do @(posedge clock); while (!req_ready);
      classify_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_frame(input int len, input logic [15:0] etype, input logic [7:0] ihl_byte,
                             input logic [7:0] proto, input logic [31:0] src,
                             input logic [31:0] dst);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom);
         if (i == fmpf_pkg::POS_TYPE_HI) b = etype[15:8];
         else if (i == fmpf_pkg::POS_TYPE_LO) b = etype[7:0];
         else if (i == fmpf_pkg::POS_IHL) b = ihl_byte;
         else if (i == fmpf_pkg::POS_PROTO) b = proto;
         else if (i >= fmpf_pkg::POS_SRC_FIRST && i <= fmpf_pkg::POS_SRC_LAST)
            b = src[8 * (int'(fmpf_pkg::POS_SRC_LAST) - i) +: 8];
         else if (i >= fmpf_pkg::POS_DST_FIRST && i <= fmpf_pkg::POS_DST_LAST)
            b = dst[8 * (int'(fmpf_pkg::POS_DST_LAST) - i) +: 8];
         send_byte(b, i == len - 1);
      end
      frames_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_verdicts.size() != 0);
   endtask

   // quiet point for register writes
   task automatic settle();
      wait_drained();
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [fmpf_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [63:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      if (index <= fmpf_pkg::REG_RULE2_CONTROL) begin
         if (index[0]) rule_ctl[index >> 1] = data[fmpf_pkg::RULE_CTL_WIDTH-1:0];
         else rule_addr[index >> 1] = data;
      end
   endtask

   task automatic send_random_frame();
      int          len;
      int          max_words;
      logic [3:0]  words;
      logic [15:0] etype;
      if ($urandom_range(0, 9) == 0) len = $urandom_range(43, 140);
      else len = $urandom_range(34, 38);
      max_words = (len - 14) / 4;
      if (max_words > 15) max_words = 15;
      words = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, max_words)) :
              fmpf_pkg::MIN_IHL_WORDS;
      etype = fmpf_pkg::IPV4_ETHERTYPE;
      // broken frames
      if ($urandom_range(0, 99) >= 75) begin
         case ($urandom_range(0, 3))
            0: len = $urandom_range(1, 33);
            1: etype = 16'($urandom);
            2: words = 4'($urandom_range(0, 4));
            default: words = 4'($urandom_range((max_words < 15) ? max_words + 1 : 15, 15));
         endcase
      end
      send_frame(len, etype, {4'($urandom), words}, pick_protocol(), pick_address(1'b1),
                 pick_address(1'b0));
   endtask

   task automatic test_default_policy();
      send_frame(34, fmpf_pkg::IPV4_ETHERTYPE, 8'h45, PROTO_TCP, HOST_A, HOST_B);
      send_frame(1, fmpf_pkg::IPV4_ETHERTYPE, 8'h45, PROTO_TCP, HOST_A, HOST_B);
      send_frame(33, fmpf_pkg::IPV4_ETHERTYPE, 8'h45, PROTO_TCP, HOST_A, HOST_B);
      send_frame(34, 16'h86DD, 8'h45, PROTO_TCP, HOST_A, HOST_B);
      send_frame(34, 16'h0801, 8'h45, PROTO_UDP, HOST_A, HOST_B);
      send_frame(34, fmpf_pkg::IPV4_ETHERTYPE, 8'h44, PROTO_TCP, HOST_A, HOST_B);
      send_frame(34, fmpf_pkg::IPV4_ETHERTYPE, 8'hF0, PROTO_TCP, HOST_A, HOST_B);
      send_frame(37, fmpf_pkg::IPV4_ETHERTYPE, 8'h46, PROTO_TCP, HOST_A, HOST_B);
      send_frame(38, fmpf_pkg::IPV4_ETHERTYPE, 8'h46, 8'h00, 32'h0, 32'h0);
      send_frame(129, fmpf_pkg::IPV4_ETHERTYPE, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_rule_order();
      settle();
      csr_write(fmpf_pkg::REG_RULE0_ADDRESSES, {HOST_A, HOST_B});
      csr_write(fmpf_pkg::REG_RULE0_CONTROL, control_word(1'b1, 1'b0, PROTO_TCP));
      csr_write(fmpf_pkg::REG_RULE1_ADDRESSES, {32'h0, HOST_B});
      csr_write(fmpf_pkg::REG_RULE1_CONTROL, control_word(1'b1, 1'b1, 8'h00));
      csr_write(fmpf_pkg::REG_RULE2_ADDRESSES, 64'h0);
      csr_write(fmpf_pkg::REG_RULE2_CONTROL, CTL_JUNK | control_word(1'b1, 1'b1, 8'h00));
      send_frame(34, fmpf_pkg::IPV4_ETHERTYPE, 8'h45, PROTO_TCP, HOST_A, HOST_B);
      send_frame(34, fmpf_pkg::IPV4_ETHERTYPE, 8'h45, PROTO_UDP, HOST_A, HOST_B);
      send_frame(34, fmpf_pkg::IPV4_ETHERTYPE, 8'h45, PROTO_TCP, HOST_C, HOST_D);
      send_frame(20, fmpf_pkg::IPV4_ETHERTYPE, 8'h45, PROTO_TCP, HOST_A, HOST_B);

      // inactive rule, writes to unused indexes
      settle();
      csr_write(fmpf_pkg::REG_RULE0_CONTROL, control_word(1'b0, 1'b1, PROTO_TCP));
      csr_write(fmpf_pkg::REG_RULE2_CONTROL, control_word(1'b1, 1'b0, 8'hFF));
      csr_write(REG_UNUSED_LO, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(REG_UNUSED_HI, 64'hFFFF_FFFF_FFFF_FFFF);
      send_frame(34, fmpf_pkg::IPV4_ETHERTYPE, 8'h45, PROTO_TCP, HOST_A, HOST_B);
      send_frame(34, fmpf_pkg::IPV4_ETHERTYPE, 8'h45, 8'hFF, HOST_C, HOST_D);
      send_frame(34, fmpf_pkg::IPV4_ETHERTYPE, 8'h45, PROTO_TCP, HOST_C, HOST_D);

      // all-ones rule fields
      settle();
      csr_write(fmpf_pkg::REG_RULE0_ADDRESSES, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(fmpf_pkg::REG_RULE0_CONTROL, control_word(1'b1, 1'b0, 8'hFF));
      csr_write(fmpf_pkg::REG_RULE1_CONTROL, 64'h0);
      csr_write(fmpf_pkg::REG_RULE2_CONTROL, CTL_JUNK);
      send_frame(34, fmpf_pkg::IPV4_ETHERTYPE, 8'h45, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_frame(34, fmpf_pkg::IPV4_ETHERTYPE, 8'h45, 8'hFF, 32'hFFFF_FFFF, 32'h0);
   endtask

   task automatic test_backpressure();
      settle();
      sender_gaps = 0;
      receiver_gaps = 0;
      stall_request = 300;
      repeat (8) send_frame(1, fmpf_pkg::IPV4_ETHERTYPE, 8'h45, PROTO_TCP, HOST_A, HOST_B);
      send_frame(34, fmpf_pkg::IPV4_ETHERTYPE, 8'h45, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      repeat (2) send_frame(2, fmpf_pkg::IPV4_ETHERTYPE, 8'h45, PROTO_TCP, HOST_A, HOST_B);
      wait_drained();
   endtask

   task automatic test_random_traffic();
      logic [31:0] s;
      logic [31:0] d;
      for (int phase = 0; phase < 4; phase++) begin
         settle();
         sender_gaps = (phase % 3) != 0;
         receiver_gaps = (phase % 4) != 1;
         for (int r = 0; r < fmpf_pkg::NUM_RULES; r++) begin
            if (phase == 0) begin
               s = '0;
               d = '0;
            end else if (phase == 1) begin
               s = '1;
               d = '1;
            end else begin
               s = ($urandom_range(0, 2) == 0) ? 32'h0 : $urandom;
               d = ($urandom_range(0, 2) == 0) ? 32'h0 : $urandom;
            end
            csr_write(fmpf_pkg::REG_RULE0_ADDRESSES + 3'(2 * r), {s, d});
            csr_write(fmpf_pkg::REG_RULE0_CONTROL + 3'(2 * r),
                      {$urandom, 22'($urandom), 1'($urandom_range(0, 3) != 0),
                       1'($urandom), ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom)});
         end
         if ($urandom_range(0, 3) == 0)
            csr_write($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI,
                      {$urandom, $urandom});
         repeat (2) send_random_frame();
      end
   endtask

   initial begin
      for (int r = 0; r < fmpf_pkg::NUM_RULES; r++) begin
         rule_addr[r] = '0;
         rule_ctl[r] = '0;
      end
      parse_pos = '0;
      parse_type = '0;
      parse_ihl = '0;
      parse_proto = '0;
      parse_src = '0;
      parse_dst = '0;
      total_seen = '0;
      total_allowed = '0;
      total_dropped = '0;
      total_invalid = '0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_frame_byte <= '0;
      req_end_of_frame <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index <= '0;
      csr_write_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_policy();
      test_rule_order();
      test_backpressure();
      test_random_traffic();

      wait_drained();
      repeat (10) @(posedge clock);
      $display("sent %0d frames in %0d bytes; checked %0d verdicts", frames_sent, bytes_sent,
               verdicts_checked);
      $display("verdicts included %0d rule drops and %0d malformed frames", drops_checked,
               invalid_checked);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: ipv4_first_match_packet_filter_unit.f
rtl/core/fmpf_pkg.sv
rtl/core/fmpf_parser.sv
rtl/core/fmpf_queue.sv
rtl/core/fmpf_matcher.sv
rtl/core/ipv4_first_match_packet_filter_unit.sv
dv/tb.sv
